// ===== rtl/core/mep_pkg.sv =====
package mep_pkg;

    // Q4.28 fixed point: 32 bit signed, 28 fraction bits
    localparam int Q_W         = 32;
    localparam int STEP_W      = 29;
    localparam int COORD_W     = 11;
    localparam int ITER_W      = 8;
    localparam int PROD_W      = 64;
    localparam int MAP_W       = STEP_W + COORD_W;   // step * coord, unsigned
    localparam int WIDE_W      = MAP_W + 2;          // origin + product, signed
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

    // reset values
    localparam logic [STEP_W-1:0]        STEP_RE_RST   = 29'd4046766;
    localparam logic [STEP_W-1:0]        STEP_IM_RST   = 29'd5422939;
    localparam logic signed [Q_W-1:0]    ORIGIN_RE_RST = -32'sd536870912;
    localparam logic signed [Q_W-1:0]    ORIGIN_IM_RST = -32'sd268435456;
    localparam logic [ITER_W-1:0]        MAX_ITER_RST  = 8'd20;

    localparam logic [ITER_W-1:0] INTENSITY_ESCAPED = 8'd255;
    localparam logic [ITER_W-1:0] INTENSITY_INSIDE  = 8'd0;

    // |z|^2 >= 4 in Q8.56 means any of bits 63..58 set
    localparam int ESC_BIT = 58;

    typedef struct packed {
        logic [STEP_W-1:0]     step_re;
        logic [STEP_W-1:0]     step_im;
        logic signed [Q_W-1:0] origin_re;
        logic signed [Q_W-1:0] origin_im;
        logic [ITER_W-1:0]     max_iter;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
    } point_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[WIDE_W-1:Q_W-1] == '0 || v[WIDE_W-1:Q_W-1] == '1) begin
            r = v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/mep_front.sv =====
module mep_front #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mep_pkg::cfg_t                   cfg,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mep_pkg::COORD_W-1:0]     s_column,
    input  logic [mep_pkg::COORD_W-1:0]     s_row,
    output logic                            q_valid,
    input  logic                            q_ready,
    output mep_pkg::point_t                 q_point
);
    import mep_pkg::*;

    logic                  prod_valid_reg, prod_valid_next;
    logic [MAP_W-1:0]      prod_re_reg, prod_im_reg;
    logic [COORD_W-1:0]    col_clamp, row_clamp;
    logic                  take;

    // clamp to the last column / row
    assign col_clamp = (32'(s_column) >= MAX_COLUMNS) ? COORD_W'(MAX_COLUMNS - 1) : s_column;
    assign row_clamp = (32'(s_row) >= MAX_ROWS)       ? COORD_W'(MAX_ROWS - 1)    : s_row;

    assign s_ready = !prod_valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        prod_valid_next = prod_valid_reg;
        if (take) begin
            prod_valid_next = 1'b1;
        end else if (q_ready) begin
            prod_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            prod_re_reg <= MAP_W'(cfg.step_re) * MAP_W'(col_clamp);
            prod_im_reg <= MAP_W'(cfg.step_im) * MAP_W'(row_clamp);
        end
    end

    // c = origin + step * coord, saturated
    assign q_valid    = prod_valid_reg;
    assign q_point.cr = sat_q(WIDE_W'(cfg.origin_re) + $signed({2'b00, prod_re_reg}));
    assign q_point.ci = sat_q(WIDE_W'(cfg.origin_im) + $signed({2'b00, prod_im_reg}));

endmodule

// ===== rtl/core/mep_queue.sv =====
module mep_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  mep_pkg::point_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output mep_pkg::point_t rd_data
);
    import mep_pkg::*;

    localparam int DEPTH = 2;

    point_t           mem [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != 2'(DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/mep_iter.sv =====
module mep_iter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mep_pkg::ITER_W-1:0]    max_iter,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  mep_pkg::point_t               q_point,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_escaped,
    output logic [mep_pkg::ITER_W-1:0]    m_iteration_count,
    output logic [mep_pkg::ITER_W-1:0]    m_intensity
);
    import mep_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [Q_W-1:0]    cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg;
    logic                     m_valid_reg, m_valid_next;
    logic                     esc_reg;
    logic [ITER_W-1:0]        cnt_reg;
    logic [ITER_W-1:0]        inten_reg;

    logic signed [PROD_W-1:0] diff;
    logic signed [Q_W-1:0]    zr_new, zi_new;
    logic [PROD_W-1:0]        mag;
    logic                     hit, limit, finish, out_free, load_z;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // next z from the registered products
    assign diff   = rr_reg - ii_reg;
    assign zr_new = sat_q(WIDE_W'(diff >>> 28) + WIDE_W'(cr_reg));
    assign zi_new = sat_q(WIDE_W'(ri_reg >>> 27) + WIDE_W'(ci_reg));

    // products of an updated z give its magnitude
    assign mag    = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign hit    = (iter_reg != '0) && (|mag[PROD_W-1:ESC_BIT]);
    assign limit  = (iter_reg == max_iter);
    assign finish = hit || limit;
    assign load_z = (state_reg == ST_UPD) && !finish;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SQ;
                    iter_next  = '0;
                end
            end
            ST_SQ: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (finish) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg <= iter_next;
        if (state_reg == ST_IDLE && q_valid) begin
            cr_reg <= q_point.cr;
            ci_reg <= q_point.ci;
            zr_reg <= q_point.cr;
            zi_reg <= q_point.ci;
        end else if (load_z) begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
        if (state_reg == ST_SQ) begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (state_reg == ST_UPD && finish && out_free) begin
            esc_reg   <= hit;
            cnt_reg   <= hit ? iter_reg - 1'b1 : max_iter;
            inten_reg <= hit ? INTENSITY_ESCAPED : INTENSITY_INSIDE;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_escaped         = esc_reg;
    assign m_iteration_count = cnt_reg;
    assign m_intensity       = inten_reg;

endmodule

// ===== rtl/core/mandelbrot_escape_pixel_core.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_valid / s_ready  | s_column[10:0], s_row[10:0]
// m_        | out       | m_valid / m_ready  | m_escaped, m_iteration_count, m_intensity
// cfg_      | in        | cfg_we             | cfg_index[2:0], cfg_wr_data[31:0]
//
// A pixel iterates in the shared complex squarer, each iteration running a square
// state (ST_SQ) then an update state (ST_UPD); the default limit is 20 iterations.
// The front maps (column,row) to c via registered products, then a 2-beat queue.
// Synchronous active-low reset clears control and loads register defaults.
// A stalled result beat sits in the output register; the next pixel keeps iterating.
module mandelbrot_escape_pixel_core #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // pixel beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mep_pkg::COORD_W-1:0]        s_column,
    input  logic [mep_pkg::COORD_W-1:0]        s_row,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_escaped,
    output logic [mep_pkg::ITER_W-1:0]         m_iteration_count,
    output logic [mep_pkg::ITER_W-1:0]         m_intensity
);
    import mep_pkg::*;

    cfg_t    cfg_reg;
    point_t  f_point, b_point;
    logic    f_valid, f_ready;
    logic    b_valid, b_ready;

    // config registers; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_re   <= STEP_RE_RST;
            cfg_reg.step_im   <= STEP_IM_RST;
            cfg_reg.origin_re <= ORIGIN_RE_RST;
            cfg_reg.origin_im <= ORIGIN_IM_RST;
            cfg_reg.max_iter  <= MAX_ITER_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_RE:   cfg_reg.step_re   <= cfg_wr_data[STEP_W-1:0];
                REG_STEP_IM:   cfg_reg.step_im   <= cfg_wr_data[STEP_W-1:0];
                REG_ORIGIN_RE: cfg_reg.origin_re <= $signed(cfg_wr_data);
                REG_ORIGIN_IM: cfg_reg.origin_im <= $signed(cfg_wr_data);
                REG_MAX_ITER:  cfg_reg.max_iter  <= cfg_wr_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: clamp, multiply by step, add origin
    mep_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_column (s_column),
        .s_row    (s_row),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_point  (f_point)
    );

    // decoupling queue between mapping and iteration
    mep_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_point),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_point)
    );

    // back: escape-time iteration and result register
    mep_iter u_iter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .max_iter          (cfg_reg.max_iter),
        .q_valid           (b_valid),
        .q_ready           (b_ready),
        .q_point           (b_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_escaped         (m_escaped),
        .m_iteration_count (m_iteration_count),
        .m_intensity       (m_intensity)
    );

endmodule
